// ----- src/dpf_pkg.sv -----
package dpf_pkg;

	// Fixed field widths
	localparam int CMD_W     = 2;
	localparam int SRC_W     = 16;
	localparam int DST_W     = 16;
	localparam int TIME_W    = 32;
	localparam int LIMIT_W   = 7;
	localparam int MCOUNT_W  = 7;

	// Defaults
	localparam int DEPTH_DEF = 64;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

	// Command codes (code 3 is a no-op)
	typedef enum logic [CMD_W-1:0] {
		CMD_ADD = 2'd0,
		CMD_FWD = 2'd1,
		CMD_CNT = 2'd2
	} cmd_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [SRC_W-1:0]  src;
		logic [DST_W-1:0]  dst;
		logic [TIME_W-1:0] tstamp;
	} pkt_t;

	// Query held steady for the whole chain pass
	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [SRC_W-1:0]  src;
		logic [DST_W-1:0]  dst;
		logic [TIME_W-1:0] tstamp;
		logic [TIME_W-1:0] lo;
		logic [TIME_W-1:0] hi;
	} query_t;

	// Broadcast update controls for the cell row
	typedef struct packed {
		logic shift;
		logic wr;
	} cell_ctrl_t;

endpackage

// ----- src/dpf_req_if.sv -----
interface dpf_req_if;
	logic                       valid;
	logic                       ready;
	logic [dpf_pkg::CMD_W-1:0]  cmd;
	logic [dpf_pkg::SRC_W-1:0]  pkt_src;
	logic [dpf_pkg::DST_W-1:0]  pkt_dst;
	logic [dpf_pkg::TIME_W-1:0] pkt_time;
	logic [dpf_pkg::TIME_W-1:0] range_start;
	logic [dpf_pkg::TIME_W-1:0] range_end;

	modport source (
		output valid, cmd, pkt_src, pkt_dst, pkt_time, range_start, range_end,
		input  ready
	);
	modport sink (
		input  valid, cmd, pkt_src, pkt_dst, pkt_time, range_start, range_end,
		output ready
	);
endinterface

// ----- src/dpf_rsp_if.sv -----
interface dpf_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         ok;
	logic [dpf_pkg::SRC_W-1:0]    out_src;
	logic [dpf_pkg::DST_W-1:0]    out_dst;
	logic [dpf_pkg::TIME_W-1:0]   out_time;
	logic [dpf_pkg::MCOUNT_W-1:0] match_count;

	modport source (
		output valid, ok, out_src, out_dst, out_time, match_count,
		input  ready
	);
	modport sink (
		input  valid, ok, out_src, out_dst, out_time, match_count,
		output ready
	);
endinterface

// ----- src/dpf_cell.sv -----
// One FIFO slot. Cell 0 holds the oldest packet; a pop shifts every cell
// one place toward cell 0. The running hit count moves one cell per cycle.
module dpf_cell #(
	parameter int DEPTH = dpf_pkg::DEPTH_DEF,
	parameter int IDX   = 0
) (
	input  logic                       clk,
	input  dpf_pkg::cell_ctrl_t        ctrl,
	input  logic [$clog2(DEPTH)-1:0]   wpos,
	input  logic [$clog2(DEPTH+1)-1:0] occ,
	input  dpf_pkg::query_t            query,
	input  dpf_pkg::pkt_t              nb_pkt,
	input  logic [$clog2(DEPTH+1)-1:0] cnt_in,
	output dpf_pkg::pkt_t              pkt,
	output logic [$clog2(DEPTH+1)-1:0] cnt_out
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);

	dpf_pkg::pkt_t   pkt_q;
	logic [CW-1:0]   cnt_q;
	logic            live;
	logic            hit;

	// Slot is live when it lies below the occupancy
	assign live = (CW'(IDX) < occ);

	// Compare against the broadcast query
	always_comb begin
		case (query.cmd)
			dpf_pkg::CMD_ADD: begin
				hit = live && (pkt_q.src == query.src) && (pkt_q.dst == query.dst)
					&& (pkt_q.tstamp == query.tstamp);
			end
			dpf_pkg::CMD_CNT: begin
				hit = live && (pkt_q.dst == query.dst)
					&& (pkt_q.tstamp >= query.lo) && (pkt_q.tstamp <= query.hi);
			end
			default: begin
				hit = 1'b0;
			end
		endcase
	end

	// Slot storage: write wins over shift
	always_ff @(posedge clk) begin
		if (ctrl.wr && (wpos == AW'(IDX))) begin
			pkt_q <= '{src: query.src, dst: query.dst, tstamp: query.tstamp};
		end else if (ctrl.shift) begin
			pkt_q <= nb_pkt;
		end
	end

	// Partial count handed to the next cell
	always_ff @(posedge clk) begin
		cnt_q <= cnt_in + CW'(hit);
	end

	assign pkt     = pkt_q;
	assign cnt_out = cnt_q;

endmodule

// ----- src/dedup_packet_fifo_with_range_count_core.sv -----
// Channel | Dir | Handshake   | Beat contents
// req     | in  | valid/ready | cmd, pkt_src, pkt_dst, pkt_time, range_start, range_end
// rsp     | out | valid/ready | ok, out_src, out_dst, out_time, match_count
// cfg     | in  | cfg_we      | cfg_wdata = memory_limit
//
// Add and count go through accept, a scan while the hit count ripples
// down the row of cells, and commit. Forward and the unused code go from
// accept straight to commit. A stalled rsp holds the commit, and req stays
// low until the beat is committed. Reset clears occupancy and the limit
// (to 64); slot contents are not cleared.
module dedup_packet_fifo_with_range_count_core #(
	parameter int DEPTH = dpf_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	dpf_req_if.sink                       req,
	dpf_rsp_if.source                     rsp,
	input  logic                          cfg_we,
	input  logic [dpf_pkg::LIMIT_W-1:0]   cfg_wdata
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);
	localparam int LW = (CW > dpf_pkg::LIMIT_W) ? CW : dpf_pkg::LIMIT_W;

	dpf_pkg::state_t               state_q, state_nxt;
	logic [dpf_pkg::LIMIT_W-1:0]   limit_q;
	logic [CW-1:0]                 occ_q, occ_nxt;
	logic [AW-1:0]                 scan_cnt_q;
	dpf_pkg::query_t               query_q;

	logic                          rsp_valid_q;
	logic                          rsp_ok_q;
	dpf_pkg::pkt_t                 rsp_pkt_q;
	logic [dpf_pkg::MCOUNT_W-1:0]  rsp_cnt_q;

	logic                          accept;
	logic                          commit;
	dpf_pkg::cell_ctrl_t           ctrl;
	logic [AW-1:0]                 wpos;
	logic                          res_ok;
	dpf_pkg::pkt_t                 res_pkt;
	logic [dpf_pkg::MCOUNT_W-1:0]  res_cnt;

	logic [LW-1:0]                 lim_ext, lim_eff, occ_ext;
	logic                          full;
	logic [CW-1:0]                 hits;
	logic                          dup;

	dpf_pkg::pkt_t                 cell_pkt [DEPTH];
	logic [CW-1:0]                 chain_cnt [DEPTH+1];

	// Row of cells
	assign chain_cnt[0] = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		dpf_cell #(
			.DEPTH (DEPTH),
			.IDX   (i)
		) u_cell (
			.clk     (clk),
			.ctrl    (ctrl),
			.wpos    (wpos),
			.occ     (occ_q),
			.query   (query_q),
			.nb_pkt  (cell_pkt[(i == DEPTH-1) ? i : i+1]),
			.cnt_in  (chain_cnt[i]),
			.pkt     (cell_pkt[i]),
			.cnt_out (chain_cnt[i+1])
		);
	end

	assign hits = chain_cnt[DEPTH];
	assign dup  = (hits != '0);

	// Effective limit, capped at the depth
	assign lim_ext = LW'(limit_q);
	assign lim_eff = (lim_ext > LW'(DEPTH)) ? LW'(DEPTH) : lim_ext;
	assign occ_ext = LW'(occ_q);
	assign full    = (occ_ext >= lim_eff);

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			dpf_pkg::ST_IDLE: begin
				if (req.valid) begin
					if (req.cmd inside {dpf_pkg::CMD_ADD, dpf_pkg::CMD_CNT}) begin
						state_nxt = dpf_pkg::ST_SCAN;
					end else begin
						state_nxt = dpf_pkg::ST_DONE;
					end
				end
			end
			dpf_pkg::ST_SCAN: begin
				if (scan_cnt_q == AW'(DEPTH-1)) begin
					state_nxt = dpf_pkg::ST_DONE;
				end
			end
			dpf_pkg::ST_DONE: begin
				if (commit) begin
					state_nxt = dpf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = dpf_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs: handshake, commit decision and cell controls
	always_comb begin
		req.ready  = (state_q == dpf_pkg::ST_IDLE);
		commit     = (state_q == dpf_pkg::ST_DONE) && (!rsp_valid_q || rsp.ready);
		ctrl       = '0;
		wpos       = AW'(occ_q);
		occ_nxt    = occ_q;
		res_ok     = 1'b0;
		res_pkt    = '0;
		res_cnt    = '0;
		case (query_q.cmd)
			dpf_pkg::CMD_ADD: begin
				res_ok = !dup;
				if (!dup && !((lim_eff == '0) && (occ_q == '0))) begin
					ctrl.wr = commit;
					if (full) begin
						// drop oldest, append in the freed tail slot
						ctrl.shift = commit;
						wpos       = AW'(occ_q - 1'b1);
					end else begin
						occ_nxt = occ_q + 1'b1;
					end
				end
			end
			dpf_pkg::CMD_FWD: begin
				if (occ_q != '0) begin
					res_ok     = 1'b1;
					res_pkt    = cell_pkt[0];
					ctrl.shift = commit;
					occ_nxt    = occ_q - 1'b1;
				end
			end
			dpf_pkg::CMD_CNT: begin
				res_cnt = dpf_pkg::MCOUNT_W'(hits);
			end
			default: begin
				res_ok = 1'b0;
			end
		endcase
	end

	assign accept = req.valid && req.ready;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dpf_pkg::ST_IDLE;
			occ_q       <= '0;
			limit_q     <= dpf_pkg::LIMIT_RESET;
			scan_cnt_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (commit) begin
				occ_q <= occ_nxt;
			end
			if (state_q == dpf_pkg::ST_SCAN) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end else begin
				scan_cnt_q <= '0;
			end
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Query and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			query_q <= '{cmd: req.cmd, src: req.pkt_src, dst: req.pkt_dst,
				tstamp: req.pkt_time, lo: req.range_start, hi: req.range_end};
		end
		if (commit) begin
			rsp_ok_q  <= res_ok;
			rsp_pkt_q <= res_pkt;
			rsp_cnt_q <= res_cnt;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.ok          = rsp_ok_q;
	assign rsp.out_src     = rsp_pkt_q.src;
	assign rsp.out_dst     = rsp_pkt_q.dst;
	assign rsp.out_time    = rsp_pkt_q.tstamp;
	assign rsp.match_count = rsp_cnt_q;

	// Checks
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(DEPTH))
		else $error("occupancy above depth");

	a_occ_at_commit: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(occ_q) |-> $past(commit))
		else $error("occupancy changed outside a commit");

	a_query_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != dpf_pkg::ST_IDLE) |=> $stable(query_q))
		else $error("query changed during a pass");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && (query_q.cmd == dpf_pkg::CMD_CNT)) |-> (hits <= occ_q))
		else $error("hit count above occupancy");

endmodule
